>>> hdl/mrb_pkg.sv
// Shared types, constants and helpers of the modal resonator bank.
// Used by mrb_front, mrb_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mrb_pkg;
	localparam int NUM_MODES_DEF = 256;
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEFS_PER_MODE = 7;
	localparam int FRAC_BITS = 29;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [1:0] REG_ACTIVE_MODES = 2'd0;
	localparam logic [1:0] REG_DRIVE_SHIFT = 2'd1;
	localparam logic [1:0] REG_OUTPUT_SHIFT = 2'd2;

	localparam logic [2:0] COEF_C1 = 3'd0;
	localparam logic [2:0] COEF_C2 = 3'd1;
	localparam logic [2:0] COEF_C3 = 3'd2;
	localparam logic [2:0] COEF_T0 = 3'd3;
	localparam logic [2:0] COEF_T1 = 3'd4;
	localparam logic [2:0] COEF_T2 = 3'd5;
	localparam logic [2:0] COEF_WEIGHT = 3'd6;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_LOAD,
		KIND_DROP
	} item_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic valid;
		item_kind_t kind;
	} head_t;

	typedef struct packed {
		logic pop;
		logic cleared;
	} back_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

>>> hdl/mrb_stream_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface mrb_in_if #(parameter int SAMPLE_WIDTH = 24);
	logic valid;
	logic ready;
	logic op;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic [7:0] mode_index;
	logic [2:0] coef_select;
	logic signed [31:0] coef_value;
	modport source(output valid, op, sample_in, mode_index, coef_select, coef_value,
		input ready);
	modport sink(input valid, op, sample_in, mode_index, coef_select, coef_value,
		output ready);
endinterface

interface mrb_out_if #(parameter int SAMPLE_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic saturated;
	modport source(output valid, sample_out, saturated, input ready);
	modport sink(input valid, sample_out, saturated, output ready);
endinterface
`default_nettype wire

>>> hdl/mrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module mrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hdl/mrb_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on mrb_pkg and mrb_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module mrb_front
	import mrb_pkg::*;
#(
	parameter int NUM_MODES = NUM_MODES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int MW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1,
	localparam int IW = (MW > 8) ? MW : 8
) (
	input wire logic clk,
	input wire logic arst_n,
	mrb_in_if.sink in,
	input wire back_ctl_t ctl,
	output head_t head,
	output logic signed [SAMPLE_WIDTH-1:0] head_sample,
	output logic [MW-1:0] head_mode,
	output logic [2:0] head_sel,
	output logic signed [31:0] head_value
);
	item_kind_t kind_q [QUEUE_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] sample_q [QUEUE_DEPTH];
	logic [MW-1:0] mode_q [QUEUE_DEPTH];
	logic [2:0] sel_q [QUEUE_DEPTH];
	logic signed [31:0] value_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0] cnt_q;
	logic push;
	logic [IW-1:0] idx_ext;
	item_kind_t kind_new;

	assign in.ready = ctl.cleared && (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push = in.valid && in.ready;
	assign idx_ext = IW'(in.mode_index);

	always_comb begin
		if (in.op == OP_SAMPLE) begin
			kind_new = KIND_SAMPLE;
		end else if ((32'(in.mode_index) < NUM_MODES) &&
				(32'(in.coef_select) < COEFS_PER_MODE)) begin
			kind_new = KIND_LOAD;
		end else begin
			kind_new = KIND_DROP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !ctl.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && ctl.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_q] <= kind_new;
			sample_q[wr_q] <= in.sample_in;
			mode_q[wr_q] <= idx_ext[MW-1:0];
			sel_q[wr_q] <= in.coef_select;
			value_q[wr_q] <= in.coef_value;
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.kind = kind_q[rd_q];
	assign head_sample = sample_q[rd_q];
	assign head_mode = mode_q[rd_q];
	assign head_sel = sel_q[rd_q];
	assign head_value = value_q[rd_q];
endmodule
`default_nettype wire

>>> hdl/mrb_back.sv
// Back end: coefficient and mode-state memories, the per-mode pipeline and the result register.
// Depends on mrb_pkg, mrb_stream_if and mrb_ram.
`timescale 1ns / 1ps
`default_nettype none
module mrb_back
	import mrb_pkg::*;
#(
	parameter int NUM_MODES = NUM_MODES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int MW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1,
	localparam int CW0 = $clog2(NUM_MODES + 1),
	localparam int CW = (CW0 > 9) ? CW0 : 9,
	localparam int ACC_W = 37 + MW
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire head_t head,
	input wire logic signed [SAMPLE_WIDTH-1:0] head_sample,
	input wire logic [MW-1:0] head_mode,
	input wire logic [2:0] head_sel,
	input wire logic signed [31:0] head_value,
	output back_ctl_t ctl,
	input wire logic [8:0] active_modes,
	input wire logic [5:0] drive_shift,
	input wire logic [5:0] output_shift,
	mrb_out_if.source out
);
	localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(2**(SAMPLE_WIDTH-1) - 1);
	localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - 1;

	back_state_t state_q, state_d;
	logic [MW-1:0] clr_q;
	logic [CW-1:0] m_q;
	logic [CW-1:0] count;
	logic issue;
	logic busy_pipe;
	logic finish;

	logic signed [SAMPLE_WIDTH-1:0] cur_q, prev_q, prev2_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [31:0] coef_rd [COEFS_PER_MODE];
	logic [63:0] state_rd;
	logic state_we;
	logic [MW-1:0] state_waddr;
	logic [63:0] state_wdata;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [MW-1:0] m_s1, m_s2, m_s3, m_s4;
	logic signed [31+SAMPLE_WIDTH:0] pe3_s2, pe4_s2, pe5_s2;
	logic signed [63:0] pr1_s2, pr2_s2;
	logic signed [31:0] c3_s2, c6_s2, now_s2;
	logic signed [31:0] exc_s3, c3_s3, c6_s3, now_s3;
	logic signed [36:0] rp_s3, rp_s4;
	logic signed [63:0] pd_s4;
	logic signed [31:0] c6_s4, now_s4;
	logic signed [31:0] rec_s5, c6_s5;
	logic signed [63:0] pw_s6;
	logic signed [31:0] exc_c, rec_c;
	logic signed [36:0] rp_c;

	logic signed [ACC_W-1:0] y_sh;
	logic signed [SAMPLE_WIDTH-1:0] y_val;
	logic y_sat;

	always_comb begin
		if (CW'(active_modes) > CW'(NUM_MODES)) begin
			count = CW'(NUM_MODES);
		end else begin
			count = CW'(active_modes);
		end
	end

	assign issue = (state_q == ST_RUN) && (m_q < count);
	assign busy_pipe = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6;
	assign finish = (!out.valid || out.ready);

	always_comb begin
		state_d = state_q;
		ctl.pop = 1'b0;
		ctl.cleared = (state_q != ST_CLEAR);
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == MW'(NUM_MODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head.valid) begin
					ctl.pop = 1'b1;
					if (head.kind == KIND_SAMPLE) begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (!issue && !busy_pipe) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			m_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			prev2_q <= '0;
			out.valid <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.pop && head.kind == KIND_SAMPLE) begin
				cur_q <= head_sample;
				m_q <= '0;
			end else if (issue) begin
				m_q <= m_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			if (state_q == ST_DONE && finish) begin
				out.valid <= 1'b1;
				prev2_q <= prev_q;
				prev_q <= cur_q;
			end else if (out.ready) begin
				out.valid <= 1'b0;
			end
		end
	end

	genvar k;
	generate
		for (k = 0; k < COEFS_PER_MODE; k++) begin : g_coef
			mrb_ram #(.WIDTH(32), .DEPTH(NUM_MODES)) u_coef (
				.clk(clk),
				.we(ctl.pop && head.kind == KIND_LOAD && head_sel == 3'(k)),
				.waddr(head_mode),
				.wdata(head_value),
				.raddr(m_q[MW-1:0]),
				.rdata(coef_rd[k])
			);
		end
	endgenerate

	assign state_we = (state_q == ST_CLEAR) || v_s4;
	assign state_waddr = (state_q == ST_CLEAR) ? clr_q : m_s4;
	assign state_wdata = (state_q == ST_CLEAR) ? 64'd0 : {rec_c, now_s4};

	mrb_ram #(.WIDTH(64), .DEPTH(NUM_MODES)) u_state (
		.clk(clk),
		.we(state_we),
		.waddr(state_waddr),
		.wdata(state_wdata),
		.raddr(m_q[MW-1:0]),
		.rdata(state_rd)
	);

	assign exc_c = sat32(66'(pe3_s2 >>> FRAC_BITS) + 66'(pe4_s2 >>> FRAC_BITS)
		+ 66'(pe5_s2 >>> FRAC_BITS));
	assign rp_c = 37'(pr1_s2 >>> FRAC_BITS) + 37'(pr2_s2 >>> FRAC_BITS);
	assign rec_c = sat32(66'(rp_s4) + 66'(pd_s4 >>> drive_shift));

	always_ff @(posedge clk) begin
		m_s1 <= m_q[MW-1:0];
		pe3_s2 <= $signed(coef_rd[COEF_T0]) * cur_q;
		pe4_s2 <= $signed(coef_rd[COEF_T1]) * prev_q;
		pe5_s2 <= $signed(coef_rd[COEF_T2]) * prev2_q;
		pr1_s2 <= $signed(coef_rd[COEF_C1]) * $signed(state_rd[63:32]);
		pr2_s2 <= $signed(coef_rd[COEF_C2]) * $signed(state_rd[31:0]);
		c3_s2 <= coef_rd[COEF_C3];
		c6_s2 <= coef_rd[COEF_WEIGHT];
		now_s2 <= state_rd[63:32];
		m_s2 <= m_s1;
		exc_s3 <= exc_c;
		rp_s3 <= rp_c;
		c3_s3 <= c3_s2;
		c6_s3 <= c6_s2;
		now_s3 <= now_s2;
		m_s3 <= m_s2;
		pd_s4 <= c3_s3 * exc_s3;
		rp_s4 <= rp_s3;
		c6_s4 <= c6_s3;
		now_s4 <= now_s3;
		m_s4 <= m_s3;
		rec_s5 <= rec_c;
		c6_s5 <= c6_s4;
		pw_s6 <= c6_s5 * rec_s5;
		if (ctl.pop) begin
			acc_q <= '0;
		end else if (v_s6) begin
			acc_q <= acc_q + ACC_W'(pw_s6 >>> FRAC_BITS);
		end
		if (state_q == ST_DONE && finish) begin
			out.sample_out <= y_val;
			out.saturated <= y_sat;
		end
	end

	always_comb begin
		y_sh = acc_q >>> output_shift;
		y_sat = 1'b1;
		if (y_sh > Y_MAX) begin
			y_val = Y_MAX[SAMPLE_WIDTH-1:0];
		end else if (y_sh < Y_MIN) begin
			y_val = Y_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y_val = y_sh[SAMPLE_WIDTH-1:0];
			y_sat = 1'b0;
		end
	end

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !busy_pipe)
		else $error("mode pipeline busy while back end idle");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> (state_q == ST_IDLE))
		else $error("queue popped outside idle state");
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (m_q <= count))
		else $error("mode counter ran past active count");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && finish) |=> (state_q == ST_IDLE && out.valid))
		else $error("result not presented after pass");
endmodule
`default_nettype wire

>>> hdl/modal_resonator_bank_unit.sv
// Top level of the modal resonator bank: configuration registers, front queue and back end.
// Depends on mrb_pkg, mrb_stream_if, mrb_front and mrb_back.
//
//  Channel | Direction | Handshake         | Payload
//  in      | sink      | valid/ready       | op, sample_in, mode_index, coef_select, coef_value
//  out     | source    | valid/ready       | sample_out, saturated
//  apb     | slave     | psel/penable      | paddr, pwdata, prdata (pready tied high)
//
// A coefficient load is written to its coefficient memory as it leaves the queue.
// A sample request passes each active mode through the per-mode pipeline, which
// reads one mode from the coefficient and state memories each cycle.
// After reset a clearing pass zeroes the state of every mode; no request
// is accepted meanwhile. A stalled result blocks the back end, while the four-entry
// queue keeps accepting requests until it is full.
`timescale 1ns / 1ps
`default_nettype none
module modal_resonator_bank_unit
	import mrb_pkg::*;
#(
	parameter int NUM_MODES = NUM_MODES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int MW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	mrb_in_if.sink in,
	mrb_out_if.source out,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [8:0] active_modes_q;
	logic [5:0] drive_shift_q;
	logic [5:0] output_shift_q;
	logic wr_en;
	head_t head;
	back_ctl_t ctl;
	logic signed [SAMPLE_WIDTH-1:0] head_sample;
	logic [MW-1:0] head_mode;
	logic [2:0] head_sel;
	logic signed [31:0] head_value;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_modes_q <= 9'd256;
			drive_shift_q <= 6'd0;
			output_shift_q <= 6'd8;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ACTIVE_MODES: active_modes_q <= pwdata[8:0];
				REG_DRIVE_SHIFT: drive_shift_q <= pwdata[5:0];
				REG_OUTPUT_SHIFT: output_shift_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ACTIVE_MODES: prdata = 32'(active_modes_q);
			REG_DRIVE_SHIFT: prdata = 32'(drive_shift_q);
			REG_OUTPUT_SHIFT: prdata = 32'(output_shift_q);
			default: prdata = 32'd0;
		endcase
	end

	mrb_front #(.NUM_MODES(NUM_MODES), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in(in),
		.ctl(ctl),
		.head(head),
		.head_sample(head_sample),
		.head_mode(head_mode),
		.head_sel(head_sel),
		.head_value(head_value)
	);

	mrb_back #(.NUM_MODES(NUM_MODES), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_sample(head_sample),
		.head_mode(head_mode),
		.head_sel(head_sel),
		.head_value(head_value),
		.ctl(ctl),
		.active_modes(active_modes_q),
		.drive_shift(drive_shift_q),
		.output_shift(output_shift_q),
		.out(out)
	);
endmodule
`default_nettype wire
